@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons)
`endif

`endif

@@ hw/rtl/pnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_pkg
// Types, constants and helpers of the palette nearest-color quantizer.
// ----------------------------------------------------------------------------
package pnc_pkg;

	localparam int unsigned PALETTE_DEPTH_DEF = 64;
	localparam int unsigned CNT_W             = 9;   // holds a count up to 511
	localparam int unsigned DIST_W            = 10;
	localparam logic [DIST_W-1:0] START_THRESHOLD = 10'd800;

	typedef enum logic [0:0] {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} op_t;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [5:0]        idx;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [DIST_W-1:0] bdist;
		logic [5:0]        bidx;
		logic [7:0]        bred;
		logic [7:0]        bgreen;
		logic [7:0]        bblue;
	} item_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ hw/rtl/palette_nearest_color_l1.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_nearest_color_l1
// Nearest palette color by sum of absolute RGB differences.
// ----------------------------------------------------------------------------
// A new request (load or classify) is taken every cycle; busy stays low.
// Each request walks a chain of PALETTE_DEPTH slot cells, one cell per cycle,
// so a classify result appears on the result ports, marked by done, as it
// leaves the last cell, and results come out in request order. Loads
// travel the same chain and produce no result. The result is
// shown for one cycle only: the receiver cannot stall and must take it then.
// The palette is undefined after reset until loaded; change palette_size
// only once all classify results are out.
module palette_nearest_color_l1 #(
	parameter int unsigned PALETTE_DEPTH = pnc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [5:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        done,
	output logic [5:0]  best_index,
	output logic [7:0]  best_red,
	output logic [7:0]  best_green,
	output logic [7:0]  best_blue,
	output logic [9:0]  best_distance
);

	`include "assert_macros.svh"

	logic [6:0]                palette_size_q;
	logic [pnc_pkg::CNT_W-1:0] size_ext;
	logic [pnc_pkg::CNT_W-1:0] count;
	logic                      accept;
	pnc_pkg::item_t            chain [PALETTE_DEPTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= 7'd1;
		end else if (cfg_we) begin
			palette_size_q <= cfg_data;
		end
	end

	// clamp the searched count to 1..PALETTE_DEPTH
	always_comb begin
		size_ext = pnc_pkg::CNT_W'(palette_size_q);
		if (size_ext == '0) begin
			count = pnc_pkg::CNT_W'(1);
		end else if (size_ext > pnc_pkg::CNT_W'(PALETTE_DEPTH)) begin
			count = pnc_pkg::CNT_W'(PALETTE_DEPTH);
		end else begin
			count = size_ext;
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		chain[0].valid  = accept;
		chain[0].op     = pnc_pkg::op_t'(opcode);
		chain[0].idx    = entry_index;
		chain[0].red    = red;
		chain[0].green  = green;
		chain[0].blue   = blue;
		chain[0].bdist  = pnc_pkg::START_THRESHOLD;
		chain[0].bidx   = '0;
		chain[0].bred   = '0;
		chain[0].bgreen = '0;
		chain[0].bblue  = '0;
	end

	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		pnc_cell #(
			.CELL_ID (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count),
			.item_in  (chain[i]),
			.item_out (chain[i+1])
		);
	end

	assign done          = chain[PALETTE_DEPTH].valid &&
	                       chain[PALETTE_DEPTH].op == pnc_pkg::OP_CLASSIFY;
	assign best_index    = chain[PALETTE_DEPTH].bidx;
	assign best_red      = chain[PALETTE_DEPTH].bred;
	assign best_green    = chain[PALETTE_DEPTH].bgreen;
	assign best_blue     = chain[PALETTE_DEPTH].bblue;
	assign best_distance = chain[PALETTE_DEPTH].bdist;

	`ASSERT_DELAY(a_classify_done, clk, arst_n, accept && opcode, PALETTE_DEPTH, done)
	`ASSERT_DELAY(a_load_silent, clk, arst_n, accept && !opcode, PALETTE_DEPTH, !done)
	`ASSERT_ALWAYS(a_count_range, clk, arst_n,
		count != '0 && count <= pnc_pkg::CNT_W'(PALETTE_DEPTH))

endmodule

@@ hw/rtl/pnc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_cell
// One palette slot: holds its entry and updates the running best of a
// passing pixel, then hands the request on to the next slot.
// ----------------------------------------------------------------------------
module pnc_cell #(
	parameter int unsigned CELL_ID = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pnc_pkg::CNT_W-1:0]  count,
	input  pnc_pkg::item_t             item_in,
	output pnc_pkg::item_t             item_out
);

	logic [23:0]                entry_q;
	logic [pnc_pkg::DIST_W-1:0] cell_dist;
	logic                       searched;
	pnc_pkg::item_t             nxt;
	pnc_pkg::item_t             item_q;
	logic                       valid_q;

	assign searched = pnc_pkg::CNT_W'(CELL_ID) < count;

	always_comb begin
		cell_dist = pnc_pkg::DIST_W'(pnc_pkg::abs_diff(item_in.red, entry_q[23:16]))
		          + pnc_pkg::DIST_W'(pnc_pkg::abs_diff(item_in.green, entry_q[15:8]))
		          + pnc_pkg::DIST_W'(pnc_pkg::abs_diff(item_in.blue, entry_q[7:0]));
		nxt = item_in;
		// strict compare keeps the lower slot on a tie
		if (item_in.op == pnc_pkg::OP_CLASSIFY && searched && cell_dist < item_in.bdist) begin
			nxt.bdist  = cell_dist;
			nxt.bidx   = 6'(CELL_ID);
			nxt.bred   = entry_q[23:16];
			nxt.bgreen = entry_q[15:8];
			nxt.bblue  = entry_q[7:0];
		end
	end

	// loads travel the chain too, so they land in order with the pixels
	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.op == pnc_pkg::OP_LOAD &&
		    pnc_pkg::CNT_W'(item_in.idx) == pnc_pkg::CNT_W'(CELL_ID)) begin
			entry_q <= {item_in.red, item_in.green, item_in.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= nxt;
	end

	always_comb begin
		item_out       = item_q;
		item_out.valid = valid_q;
	end

endmodule
